### rtl/gotc_pkg.sv
// Shared types, constants and helpers for the group offset table closure block.
// Used by the controller, the datapath and the top level; depends on nothing.
package gotc_pkg;

  localparam int MAX_GROUPS = 64;
  localparam int DEPTH      = MAX_GROUPS * MAX_GROUPS;
  localparam int ADDR_W     = $clog2(DEPTH);
  // Loop counters must hold one more than the last group plus one.
  localparam int COUNT_W    = $clog2(MAX_GROUPS + 2);

  localparam int CMD_W    = 2;
  localparam int GROUP_W  = 6;
  localparam int OFS_W    = 32;
  localparam int PASS_W   = 8;
  localparam int CFG_W    = 7;
  localparam int STATUS_W = 2;

  localparam logic [STATUS_W-1:0] ST_OK       = 2'd0;
  localparam logic [STATUS_W-1:0] ST_SAME     = 2'd1;
  localparam logic [STATUS_W-1:0] ST_INVALID  = 2'd2;
  localparam logic [STATUS_W-1:0] ST_MISMATCH = 2'd3;

  typedef enum logic [CMD_W-1:0] {
    OP_CLEAR,
    OP_ADD,
    OP_CLOSE,
    OP_READ
  } op_t;

  typedef struct packed {
    logic              set;
    logic [PASS_W-1:0] pass;
    logic [OFS_W-1:0]  x;
    logic [OFS_W-1:0]  y;
  } entry_t;

  localparam int ENTRY_W = $bits(entry_t);

  typedef enum logic [4:0] {
    S_INIT,
    S_IDLE,
    S_CLEAR,
    S_ADD,
    S_ADD_CHK,
    S_READ,
    S_READ_OUT,
    S_P1_TEST,
    S_P1_RDQ,
    S_P1_CMP,
    S_P2_PASS,
    S_XY_TEST,
    S_XY_DATA,
    S_Z_TEST,
    S_YZ_DATA,
    S_XZ_DATA,
    S_PASS_END
  } state_t;

  typedef enum logic [2:0] {RS_IN, RS_XY, RS_YX, RS_YZ, RS_XZ} rsel_t;
  typedef enum logic [1:0] {WS_CLR, WS_LINK, WS_SUM} wsel_t;
  typedef enum logic [2:0] {
    XY_HOLD,
    XY_P1_INIT,
    XY_P1_ROW,
    XY_P2_INIT,
    XY_P2_ROW,
    XY_Y_INC
  } xyop_t;
  typedef enum logic [1:0] {Z_HOLD, Z_INIT, Z_INC} zop_t;
  typedef enum logic [2:0] {
    RES_NONE,
    RES_ADD_ERR,
    RES_ADD,
    RES_READ,
    RES_CLOSE,
    RES_CLEAR
  } res_t;

  typedef struct packed {
    logic  latch_in;
    rsel_t rd_sel;
    logic  wr_en;
    wsel_t wr_sel;
    logic  clr_inc;
    xyop_t xy_op;
    zop_t  z_op;
    logic  hold_load;
    logic  p1_check;
    logic  sum_load;
    logic  xz_resolve;
    logic  pass_inc;
    res_t  res;
  } cmd_t;

  typedef struct packed {
    logic x_end;
    logic y_end;
    logic z_end;
    logic clr_last;
    logic rd_set;
    logic add_err;
    logic grew;
  } stat_t;

  function automatic logic [ADDR_W-1:0] cell_addr(input logic [31:0] row,
                                                  input logic [31:0] col);
    logic [31:0] flat;
    flat = row * MAX_GROUPS + col;
    return flat[ADDR_W-1:0];
  endfunction

endpackage

### rtl/gotc_ram.sv
// Generic single-port-write, single-port-read RAM with a registered read.
// Stand-alone; no package needed.
module gotc_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 16
) (
  input  logic                     clk,
  input  logic                     wr_en,
  input  logic [$clog2(DEPTH)-1:0] wr_addr,
  input  logic [WIDTH-1:0]         wr_data,
  input  logic [$clog2(DEPTH)-1:0] rd_addr,
  output logic [WIDTH-1:0]         rd_data
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem[wr_addr] <= wr_data;
    end
    rd_data <= mem[rd_addr];
  end

endmodule

### rtl/gotc_ctrl.sv
// Controller state machine for the group offset table closure block.
// Depends on gotc_pkg; drives the datapath through cmd_t and reads stat_t.
module gotc_ctrl (
  input  logic                       clk,
  input  logic                       rst,
  input  logic                       start,
  input  logic [gotc_pkg::CMD_W-1:0] command,
  input  gotc_pkg::stat_t            stat,
  output logic                       busy,
  output gotc_pkg::cmd_t             cmd
);
  import gotc_pkg::*;

  state_t state;
  state_t state_next;
  op_t    op;

  assign op   = op_t'(command);
  assign busy = (state != S_IDLE);

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= S_INIT;
    end else begin
      state <= state_next;
    end
  end

  always_comb begin
    state_next = state;
    unique case (state)
      S_INIT: begin
        if (stat.clr_last) state_next = S_IDLE;
      end
      S_IDLE: begin
        if (start) begin
          unique case (op)
            OP_CLEAR: state_next = S_CLEAR;
            OP_ADD:   state_next = S_ADD;
            OP_CLOSE: state_next = S_P1_TEST;
            OP_READ:  state_next = S_READ;
          endcase
        end
      end
      S_CLEAR: begin
        if (stat.clr_last) state_next = S_IDLE;
      end
      S_ADD: begin
        state_next = stat.add_err ? S_IDLE : S_ADD_CHK;
      end
      S_ADD_CHK:  state_next = S_IDLE;
      S_READ:     state_next = S_READ_OUT;
      S_READ_OUT: state_next = S_IDLE;
      S_P1_TEST: begin
        if (stat.x_end) begin
          state_next = S_P2_PASS;
        end else if (!stat.y_end) begin
          state_next = S_P1_RDQ;
        end
      end
      S_P1_RDQ:  state_next = S_P1_CMP;
      S_P1_CMP:  state_next = S_P1_TEST;
      S_P2_PASS: state_next = S_XY_TEST;
      S_XY_TEST: begin
        if (stat.x_end) begin
          state_next = S_PASS_END;
        end else if (!stat.y_end) begin
          state_next = S_XY_DATA;
        end
      end
      S_XY_DATA: begin
        state_next = stat.rd_set ? S_Z_TEST : S_XY_TEST;
      end
      S_Z_TEST: begin
        state_next = stat.z_end ? S_XY_TEST : S_YZ_DATA;
      end
      S_YZ_DATA: begin
        state_next = stat.rd_set ? S_XZ_DATA : S_Z_TEST;
      end
      S_XZ_DATA: state_next = S_Z_TEST;
      S_PASS_END: begin
        state_next = stat.grew ? S_P2_PASS : S_IDLE;
      end
      default: state_next = S_INIT;
    endcase
  end

  always_comb begin
    cmd = '0;
    unique case (state)
      S_INIT: begin
        cmd.wr_en   = 1'b1;
        cmd.wr_sel  = WS_CLR;
        cmd.clr_inc = 1'b1;
      end
      S_IDLE: begin
        if (start) begin
          cmd.latch_in = 1'b1;
          if (op == OP_CLOSE) cmd.xy_op = XY_P1_INIT;
        end
      end
      S_CLEAR: begin
        cmd.wr_en   = 1'b1;
        cmd.wr_sel  = WS_CLR;
        cmd.clr_inc = 1'b1;
        if (stat.clr_last) cmd.res = RES_CLEAR;
      end
      S_ADD: begin
        if (stat.add_err) begin
          cmd.res = RES_ADD_ERR;
        end else begin
          cmd.rd_sel = RS_IN;
        end
      end
      S_ADD_CHK: begin
        cmd.wr_en  = !stat.rd_set;
        cmd.wr_sel = WS_LINK;
        cmd.res    = RES_ADD;
      end
      S_READ: begin
        cmd.rd_sel = RS_IN;
      end
      S_READ_OUT: begin
        cmd.res = RES_READ;
      end
      S_P1_TEST: begin
        if (!stat.x_end) begin
          if (stat.y_end) begin
            cmd.xy_op = XY_P1_ROW;
          end else begin
            cmd.rd_sel = RS_XY;
          end
        end
      end
      S_P1_RDQ: begin
        cmd.rd_sel    = RS_YX;
        cmd.hold_load = 1'b1;
      end
      S_P1_CMP: begin
        cmd.p1_check = 1'b1;
        cmd.xy_op    = XY_Y_INC;
      end
      S_P2_PASS: begin
        cmd.xy_op = XY_P2_INIT;
      end
      S_XY_TEST: begin
        if (!stat.x_end) begin
          if (stat.y_end) begin
            cmd.xy_op = XY_P2_ROW;
          end else begin
            cmd.rd_sel = RS_XY;
          end
        end
      end
      S_XY_DATA: begin
        cmd.hold_load = 1'b1;
        if (stat.rd_set) begin
          cmd.z_op = Z_INIT;
        end else begin
          cmd.xy_op = XY_Y_INC;
        end
      end
      S_Z_TEST: begin
        if (stat.z_end) begin
          cmd.xy_op = XY_Y_INC;
        end else begin
          cmd.rd_sel = RS_YZ;
        end
      end
      S_YZ_DATA: begin
        if (stat.rd_set) begin
          cmd.sum_load = 1'b1;
          cmd.rd_sel   = RS_XZ;
        end else begin
          cmd.z_op = Z_INC;
        end
      end
      S_XZ_DATA: begin
        cmd.xz_resolve = 1'b1;
        cmd.wr_en      = !stat.rd_set;
        cmd.wr_sel     = WS_SUM;
        cmd.z_op       = Z_INC;
      end
      S_PASS_END: begin
        cmd.pass_inc = 1'b1;
        if (!stat.grew) cmd.res = RES_CLOSE;
      end
      default: cmd = '0;
    endcase
  end

endmodule

### rtl/gotc_dp.sv
// Datapath of the group offset table closure block: table RAM, loop counters,
// operand and sum registers, result registers. Depends on gotc_pkg and gotc_ram.
module gotc_dp (
  input  logic                                 clk,
  input  logic                                 rst,
  input  gotc_pkg::cmd_t                       cmd,
  output gotc_pkg::stat_t                      stat,
  input  logic                                 cfg_we,
  input  logic        [gotc_pkg::CFG_W-1:0]    cfg_data,
  input  logic        [gotc_pkg::GROUP_W-1:0]  from_group,
  input  logic        [gotc_pkg::GROUP_W-1:0]  to_group,
  input  logic signed [gotc_pkg::OFS_W-1:0]    offset_x,
  input  logic signed [gotc_pkg::OFS_W-1:0]    offset_y,
  output logic                                 done,
  output logic        [gotc_pkg::STATUS_W-1:0] status,
  output logic                                 inconsistent,
  output logic                                 entry_valid,
  output logic signed [gotc_pkg::OFS_W-1:0]    entry_x,
  output logic signed [gotc_pkg::OFS_W-1:0]    entry_y,
  output logic        [gotc_pkg::PASS_W-1:0]   entry_pass
);
  import gotc_pkg::*;

  logic [CFG_W-1:0]   group_count;
  logic [COUNT_W-1:0] n;
  logic [GROUP_W-1:0] in_a;
  logic [GROUP_W-1:0] in_b;
  logic [OFS_W-1:0]   in_dx;
  logic [OFS_W-1:0]   in_dy;
  logic [COUNT_W-1:0] x;
  logic [COUNT_W-1:0] y;
  logic [COUNT_W-1:0] z;
  logic [ADDR_W-1:0]  clr_addr;
  logic [PASS_W-1:0]  pass;
  logic               bad;
  logic               grew;
  entry_t             hold;
  logic [OFS_W-1:0]   sum_x;
  logic [OFS_W-1:0]   sum_y;

  logic               wr_en;
  logic [ADDR_W-1:0]  wr_addr;
  entry_t             wr_entry;
  logic [ADDR_W-1:0]  rd_addr;
  logic [ENTRY_W-1:0] rd_data;
  entry_t             rd_entry;
  logic               same_group;
  logic               bad_group;
  logic               in_range;
  logic               clr_last;

  // The size in use saturates at the table size.
  always_comb begin
    if (32'(group_count) > 32'(MAX_GROUPS)) begin
      n = COUNT_W'(MAX_GROUPS);
    end else begin
      n = COUNT_W'(group_count);
    end
  end

  assign rd_entry   = entry_t'(rd_data);
  assign same_group = (in_a == in_b);
  assign bad_group  = (in_a == '0) || (32'(in_a) >= 32'(n)) ||
                      (in_b == '0) || (32'(in_b) >= 32'(n));
  assign in_range   = (32'(in_a) < 32'(MAX_GROUPS)) && (32'(in_b) < 32'(MAX_GROUPS));
  assign clr_last   = (clr_addr == ADDR_W'(DEPTH - 1));

  assign stat.x_end    = (x >= n);
  assign stat.y_end    = (y >= n);
  assign stat.z_end    = (z >= n);
  assign stat.clr_last = clr_last;
  assign stat.rd_set   = rd_entry.set;
  assign stat.add_err  = same_group || bad_group;
  assign stat.grew     = grew;

  always_comb begin
    unique case (cmd.rd_sel)
      RS_IN:   rd_addr = cell_addr(32'(in_a), 32'(in_b));
      RS_XY:   rd_addr = cell_addr(32'(x), 32'(y));
      RS_YX:   rd_addr = cell_addr(32'(y), 32'(x));
      RS_YZ:   rd_addr = cell_addr(32'(y), 32'(z));
      RS_XZ:   rd_addr = cell_addr(32'(x), 32'(z));
      default: rd_addr = cell_addr(32'(in_a), 32'(in_b));
    endcase
  end

  always_comb begin
    wr_en = cmd.wr_en;
    unique case (cmd.wr_sel)
      WS_CLR: begin
        wr_addr  = clr_addr;
        wr_entry = '0;
      end
      WS_LINK: begin
        wr_addr  = cell_addr(32'(in_a), 32'(in_b));
        wr_entry = '{set: 1'b1, pass: '0, x: in_dx, y: in_dy};
      end
      WS_SUM: begin
        wr_addr  = cell_addr(32'(x), 32'(z));
        wr_entry = '{set: 1'b1, pass: pass, x: sum_x, y: sum_y};
      end
      default: begin
        wr_addr  = clr_addr;
        wr_entry = '0;
      end
    endcase
  end

  gotc_ram #(
    .WIDTH(ENTRY_W),
    .DEPTH(DEPTH)
  ) u_table (
    .clk    (clk),
    .wr_en  (wr_en),
    .wr_addr(wr_addr),
    .wr_data(wr_entry),
    .rd_addr(rd_addr),
    .rd_data(rd_data)
  );

  // Control registers: configuration, counters, flags and the result strobe.
  always_ff @(posedge clk) begin
    if (rst) begin
      group_count <= CFG_W'(1);
      clr_addr    <= '0;
      x           <= '0;
      y           <= '0;
      z           <= '0;
      pass        <= '0;
      bad         <= 1'b0;
      grew        <= 1'b0;
      done        <= 1'b0;
    end else begin
      if (cfg_we) group_count <= cfg_data;

      if (cmd.clr_inc) begin
        clr_addr <= clr_last ? '0 : clr_addr + ADDR_W'(1);
      end

      unique case (cmd.xy_op)
        XY_HOLD: ;
        XY_P1_INIT: begin
          x    <= COUNT_W'(1);
          y    <= COUNT_W'(2);
          bad  <= 1'b0;
          pass <= PASS_W'(1);
        end
        XY_P1_ROW: begin
          x <= x + COUNT_W'(1);
          y <= x + COUNT_W'(2);
        end
        XY_P2_INIT: begin
          x    <= COUNT_W'(1);
          y    <= COUNT_W'(1);
          grew <= 1'b0;
        end
        XY_P2_ROW: begin
          x <= x + COUNT_W'(1);
          y <= COUNT_W'(1);
        end
        XY_Y_INC: y <= y + COUNT_W'(1);
        default: ;
      endcase

      unique case (cmd.z_op)
        Z_HOLD: ;
        Z_INIT: z <= COUNT_W'(1);
        Z_INC:  z <= z + COUNT_W'(1);
        default: ;
      endcase

      if (cmd.pass_inc) pass <= pass + PASS_W'(1);

      // Opposite entries must cancel exactly, with 32-bit wrap.
      if (cmd.p1_check && hold.set && rd_entry.set &&
          ((hold.x != (32'd0 - rd_entry.x)) || (hold.y != (32'd0 - rd_entry.y)))) begin
        bad <= 1'b1;
      end

      if (cmd.xz_resolve) begin
        if (rd_entry.set) begin
          if ((rd_entry.x != sum_x) || (rd_entry.y != sum_y)) bad <= 1'b1;
        end else begin
          grew <= 1'b1;
        end
      end

      done <= (cmd.res != RES_NONE);
    end
  end

  // Payload registers.
  always_ff @(posedge clk) begin
    if (cmd.latch_in) begin
      in_a  <= from_group;
      in_b  <= to_group;
      in_dx <= $unsigned(offset_x);
      in_dy <= $unsigned(offset_y);
    end
    if (cmd.hold_load) hold <= rd_entry;
    if (cmd.sum_load) begin
      sum_x <= hold.x + rd_entry.x;
      sum_y <= hold.y + rd_entry.y;
    end

    unique case (cmd.res)
      RES_NONE: ;
      RES_ADD_ERR: begin
        status       <= same_group ? ST_SAME : ST_INVALID;
        inconsistent <= 1'b0;
        entry_valid  <= 1'b0;
        entry_x      <= '0;
        entry_y      <= '0;
        entry_pass   <= '0;
      end
      RES_ADD: begin
        status       <= (rd_entry.set && ((rd_entry.x != in_dx) || (rd_entry.y != in_dy)))
                        ? ST_MISMATCH : ST_OK;
        inconsistent <= 1'b0;
        entry_valid  <= 1'b0;
        entry_x      <= '0;
        entry_y      <= '0;
        entry_pass   <= '0;
      end
      RES_READ: begin
        status       <= ST_OK;
        inconsistent <= 1'b0;
        entry_valid  <= in_range && rd_entry.set;
        entry_x      <= in_range ? $signed(rd_entry.x) : '0;
        entry_y      <= in_range ? $signed(rd_entry.y) : '0;
        entry_pass   <= in_range ? rd_entry.pass : '0;
      end
      RES_CLOSE: begin
        status       <= ST_OK;
        inconsistent <= bad;
        entry_valid  <= 1'b0;
        entry_x      <= '0;
        entry_y      <= '0;
        entry_pass   <= '0;
      end
      RES_CLEAR: begin
        status       <= ST_OK;
        inconsistent <= 1'b0;
        entry_valid  <= 1'b0;
        entry_x      <= '0;
        entry_y      <= '0;
        entry_pass   <= '0;
      end
      default: ;
    endcase
  end

endmodule

### rtl/group_offset_table_closure.sv
// Top level of the group offset table closure block.
// Depends on gotc_pkg, gotc_ctrl, gotc_dp (which holds gotc_ram).
//
// An item is taken when start is high and busy is low; its result appears on
// the result ports for exactly one cycle with done high, and the receiver
// cannot stall it. One item is worked on at a time, and every access goes
// through the single read port of a 4096-entry table RAM, which sets the
// timing. After reset the block clears the whole table with busy high;
// configuration writes are taken whenever busy is low. Add checks the
// groups and reads the table only if they are valid; read looks up one
// entry; clear walks every cell. Close first checks each pair x<y row by
// row, then in each pass visits every (x, y) entry, sweeps z on rows whose
// (x, y) is set and resolves (x, z) for each z whose (y, z) is set;
// passes repeat until one adds no entry. done of one item may share a cycle
// with the acceptance of the next.
module group_offset_table_closure (
  input  logic                                 clk,
  input  logic                                 rst,
  input  logic                                 start,
  output logic                                 busy,
  input  logic        [gotc_pkg::CMD_W-1:0]    command,
  input  logic        [gotc_pkg::GROUP_W-1:0]  from_group,
  input  logic        [gotc_pkg::GROUP_W-1:0]  to_group,
  input  logic signed [gotc_pkg::OFS_W-1:0]    offset_x,
  input  logic signed [gotc_pkg::OFS_W-1:0]    offset_y,
  output logic                                 done,
  output logic        [gotc_pkg::STATUS_W-1:0] status,
  output logic                                 inconsistent,
  output logic                                 entry_valid,
  output logic signed [gotc_pkg::OFS_W-1:0]    entry_x,
  output logic signed [gotc_pkg::OFS_W-1:0]    entry_y,
  output logic        [gotc_pkg::PASS_W-1:0]   entry_pass,
  input  logic                                 cfg_valid,
  output logic                                 cfg_ready,
  input  logic        [gotc_pkg::CFG_W-1:0]    cfg_data
);
  import gotc_pkg::*;

  cmd_t  cmd;
  stat_t stat;
  logic  cfg_we;

  assign cfg_ready = !busy;
  assign cfg_we    = cfg_valid && cfg_ready;

  gotc_ctrl u_ctrl (
    .clk    (clk),
    .rst    (rst),
    .start  (start),
    .command(command),
    .stat   (stat),
    .busy   (busy),
    .cmd    (cmd)
  );

  gotc_dp u_dp (
    .clk         (clk),
    .rst         (rst),
    .cmd         (cmd),
    .stat        (stat),
    .cfg_we      (cfg_we),
    .cfg_data    (cfg_data),
    .from_group  (from_group),
    .to_group    (to_group),
    .offset_x    (offset_x),
    .offset_y    (offset_y),
    .done        (done),
    .status      (status),
    .inconsistent(inconsistent),
    .entry_valid (entry_valid),
    .entry_x     (entry_x),
    .entry_y     (entry_y),
    .entry_pass  (entry_pass)
  );

`ifndef SYNTHESIS
  // Every accepted item keeps the block busy for at least the next cycle.
  a_start_busy: assert property (@(posedge clk) disable iff (rst)
    (start && !busy) |=> busy)
    else $error("accepted item did not make the block busy");

  // A result is only produced by work done while busy.
  a_done_after_busy: assert property (@(posedge clk) disable iff (rst)
    done |-> $past(busy))
    else $error("result strobe without preceding work");

  // The table is never written while the block is idle.
  a_write_busy: assert property (@(posedge clk) disable iff (rst)
    cmd.wr_en |-> busy)
    else $error("table write while idle");
`endif

endmodule

### tb/sv/offset_table_checker.sv
// Result checker for the group offset table closure block: keeps its own copy of the
// offset table, predicts every item's result and compares the block's results in order.
// Depends on gotc_pkg for widths, command codes and status codes.
`timescale 1ns / 1ps

module offset_table_checker (
  input  logic                          clk,
  input  logic                          rst,
  input  logic                          start,
  input  logic                          busy,
  input  logic [gotc_pkg::CMD_W-1:0]    command,
  input  logic [gotc_pkg::GROUP_W-1:0]  from_group,
  input  logic [gotc_pkg::GROUP_W-1:0]  to_group,
  input  logic [gotc_pkg::OFS_W-1:0]    offset_x,
  input  logic [gotc_pkg::OFS_W-1:0]    offset_y,
  input  logic                          done,
  input  logic [gotc_pkg::STATUS_W-1:0] status,
  input  logic                          inconsistent,
  input  logic                          entry_valid,
  input  logic [gotc_pkg::OFS_W-1:0]    entry_x,
  input  logic [gotc_pkg::OFS_W-1:0]    entry_y,
  input  logic [gotc_pkg::PASS_W-1:0]   entry_pass,
  input  logic                          cfg_valid,
  input  logic                          cfg_ready,
  input  logic [gotc_pkg::CFG_W-1:0]    cfg_data,
  output int                            failures,
  output int                            outstanding,
  output int                            results_seen
);
  import gotc_pkg::*;

  localparam int REPORT_CAP = 100;

  typedef struct packed {
    logic [STATUS_W-1:0] status;
    logic                inconsistent;
    logic                valid;
    logic [OFS_W-1:0]    x;
    logic [OFS_W-1:0]    y;
    logic [PASS_W-1:0]   pass;
  } outcome_t;

  logic [OFS_W-1:0]  ofs_x     [DEPTH];
  logic [OFS_W-1:0]  ofs_y     [DEPTH];
  logic              is_set    [DEPTH];
  logic [PASS_W-1:0] fill_pass [DEPTH];
  logic [CFG_W-1:0]  group_count;
  outcome_t          awaited [$];
  outcome_t          want;
  int                idx;
  int                fail_count   = 0;
  int                result_count = 0;
  int                waiting      = 0;

  assign failures     = fail_count;
  assign outstanding  = waiting;
  assign results_seen = result_count;

  // Register values above the table size act as the full table.
  function automatic int live_groups();
    return (group_count > MAX_GROUPS) ? MAX_GROUPS : int'(group_count);
  endfunction

  function automatic int slot(input int row, input int col);
    return row * MAX_GROUPS + col;
  endfunction

  function automatic void wipe_table();
    for (int c = 0; c < DEPTH; c++) begin
      ofs_x[c]     = '0;
      ofs_y[c]     = '0;
      is_set[c]    = 1'b0;
      fill_pass[c] = '0;
    end
  endfunction

  function automatic logic [STATUS_W-1:0] store_link(input int a, b,
                                                     input logic [OFS_W-1:0] dx, dy);
    int n;
    int c;
    n = live_groups();
    c = slot(a, b);
    if (a == b) return ST_SAME;
    if (a == 0 || a >= n || b == 0 || b >= n) return ST_INVALID;
    if (!is_set[c]) begin
      ofs_x[c]     = dx;
      ofs_y[c]     = dy;
      is_set[c]    = 1'b1;
      fill_pass[c] = '0;
      return ST_OK;
    end
    if (ofs_x[c] != dx || ofs_y[c] != dy) return ST_MISMATCH;
    return ST_OK;
  endfunction

  // Opposite-pair check first, then closure sweeps in row order until one adds nothing.
  // Entries filled earlier in a sweep feed later steps of that same sweep.
  function automatic logic settle_offsets();
    int                n;
    int                p;
    int                q;
    int                xy;
    int                yz;
    int                xz;
    logic              conflict;
    logic              grew;
    logic [PASS_W-1:0] pass_no;
    logic [OFS_W-1:0]  sx;
    logic [OFS_W-1:0]  sy;
    n = live_groups();
    conflict = 1'b0;
    pass_no = PASS_W'(1);
    for (int x = 1; x < n; x++) begin
      for (int y = x + 1; y < n; y++) begin
        p = slot(x, y);
        q = slot(y, x);
        if (is_set[p] && is_set[q] && (ofs_x[p] != -ofs_x[q] || ofs_y[p] != -ofs_y[q]))
          conflict = 1'b1;
      end
    end
    do begin
      grew = 1'b0;
      for (int x = 1; x < n; x++) begin
        for (int y = 1; y < n; y++) begin
          xy = slot(x, y);
          if (is_set[xy]) begin
            for (int z = 1; z < n; z++) begin
              yz = slot(y, z);
              xz = slot(x, z);
              if (is_set[yz]) begin
                sx = ofs_x[xy] + ofs_x[yz];
                sy = ofs_y[xy] + ofs_y[yz];
                if (is_set[xz]) begin
                  if (sx != ofs_x[xz] || sy != ofs_y[xz]) conflict = 1'b1;
                end else begin
                  ofs_x[xz]     = sx;
                  ofs_y[xz]     = sy;
                  is_set[xz]    = 1'b1;
                  fill_pass[xz] = pass_no;
                  grew          = 1'b1;
                end
              end
            end
          end
        end
      end
      pass_no = pass_no + 1'b1;
    end while (grew);
    return conflict;
  endfunction

  function automatic void check_field(input string name, input logic [OFS_W-1:0] exp_v,
                                      input logic [OFS_W-1:0] act_v);
    if (act_v !== exp_v) begin
      fail_count++;
      if (fail_count <= REPORT_CAP)
        $error("%s: expected 0x%0h, got 0x%0h", name, exp_v, act_v);
    end
  endfunction

  always @(posedge clk) begin
    if (rst) begin
      wipe_table();
      group_count = 7'd1;
      awaited.delete();
    end else begin
      // A result may share an edge with the next item, so results go first.
      if (done) begin
        if (awaited.size() == 0) begin
          fail_count++;
          if (fail_count <= REPORT_CAP) $error("result arrived with no item waiting for it");
        end else begin
          want = awaited.pop_front();
          result_count++;
          check_field("status", OFS_W'(want.status), OFS_W'(status));
          check_field("inconsistent", OFS_W'(want.inconsistent), OFS_W'(inconsistent));
          check_field("entry_valid", OFS_W'(want.valid), OFS_W'(entry_valid));
          check_field("entry_x", want.x, entry_x);
          check_field("entry_y", want.y, entry_y);
          check_field("entry_pass", OFS_W'(want.pass), OFS_W'(entry_pass));
        end
      end
      if (cfg_valid && cfg_ready) group_count = cfg_data;
      if (start && !busy) begin
        want = '0;
        case (op_t'(command))
          OP_CLEAR: wipe_table();
          OP_ADD:   want.status = store_link(int'(from_group), int'(to_group),
                                             offset_x, offset_y);
          OP_CLOSE: want.inconsistent = settle_offsets();
          default: begin
            // Reads see stored entries whatever the size in use.
            idx = slot(int'(from_group), int'(to_group));
            want.valid = is_set[idx];
            want.x     = ofs_x[idx];
            want.y     = ofs_y[idx];
            want.pass  = fill_pass[idx];
          end
        endcase
        awaited.push_back(want);
      end
    end
    waiting <= awaited.size();
  end

endmodule

### tb/sv/testbench.sv
// Top of the group offset table closure testbench: clock, reset, item and size stimulus,
// and the verdict. Depends on gotc_pkg, group_offset_table_closure and offset_table_checker.
`timescale 1ns / 1ps

module testbench;
  import gotc_pkg::*;

  // The limit leaves ample margin for a correct run, in which every clear walks the whole
  // table and a close at the full table size is slow.
  localparam int LIMIT_CYCLES = 6_000_000;
  localparam int PHASE_ITEMS  = 85;
  localparam int WIDE_ITEMS   = 40;
  localparam int GROUP_TOP    = (1 << GROUP_W) - 1;

  logic                    clk        = 1'b0;
  logic                    rst        = 1'b1;
  logic                    start      = 1'b0;
  op_t                     command    = OP_CLEAR;
  logic [GROUP_W-1:0]      from_group = '0;
  logic [GROUP_W-1:0]      to_group   = '0;
  logic signed [OFS_W-1:0] offset_x   = '0;
  logic signed [OFS_W-1:0] offset_y   = '0;
  logic                    cfg_valid  = 1'b0;
  logic [CFG_W-1:0]        cfg_data   = '0;

  logic                    busy;
  logic                    done;
  logic [STATUS_W-1:0]     status;
  logic                    inconsistent;
  logic                    entry_valid;
  logic signed [OFS_W-1:0] entry_x;
  logic signed [OFS_W-1:0] entry_y;
  logic [PASS_W-1:0]       entry_pass;
  logic                    cfg_ready;

  int failures;
  int outstanding;
  int results_seen;

  int               live        = 1;
  int               burst_left  = 1;
  int               size_writes = 0;
  int               op_counts [4] = '{0, 0, 0, 0};
  int               phase_sizes [18] = '{3, 5, 2, 8, 4, 6, 1, 7, 10, 5, 0, 3, 9, 4, 6, 2, 8, 3};
  logic [OFS_W-1:0] anchor_x [MAX_GROUPS];
  logic [OFS_W-1:0] anchor_y [MAX_GROUPS];

  always #5 clk = ~clk;

  group_offset_table_closure dut (
    .clk          (clk),
    .rst          (rst),
    .start        (start),
    .busy         (busy),
    .command      (command),
    .from_group   (from_group),
    .to_group     (to_group),
    .offset_x     (offset_x),
    .offset_y     (offset_y),
    .done         (done),
    .status       (status),
    .inconsistent (inconsistent),
    .entry_valid  (entry_valid),
    .entry_x      (entry_x),
    .entry_y      (entry_y),
    .entry_pass   (entry_pass),
    .cfg_valid    (cfg_valid),
    .cfg_ready    (cfg_ready),
    .cfg_data     (cfg_data)
  );

  offset_table_checker table_check (
    .clk          (clk),
    .rst          (rst),
    .start        (start),
    .busy         (busy),
    .command      (command),
    .from_group   (from_group),
    .to_group     (to_group),
    .offset_x     (offset_x),
    .offset_y     (offset_y),
    .done         (done),
    .status       (status),
    .inconsistent (inconsistent),
    .entry_valid  (entry_valid),
    .entry_x      (entry_x),
    .entry_y      (entry_y),
    .entry_pass   (entry_pass),
    .cfg_valid    (cfg_valid),
    .cfg_ready    (cfg_ready),
    .cfg_data     (cfg_data),
    .failures     (failures),
    .outstanding  (outstanding),
    .results_seen (results_seen)
  );

  // Each group gets a random position; links taken from position differences never conflict.
  task automatic place_groups();
    for (int i = 0; i < MAX_GROUPS; i++) begin
      anchor_x[i] = $urandom();
      anchor_y[i] = $urandom();
    end
  endtask

  // Bursts of random length, mostly short, now and then long stretches with no gaps.
  task automatic pace();
    int gap;
    burst_left--;
    if (burst_left <= 0) begin
      gap = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 15);
      burst_left = ($urandom_range(0, 4) == 0) ? $urandom_range(30, 60) : $urandom_range(1, 10);
      if (gap > 0) begin
        start <= 1'b0;
        repeat (gap) @(posedge clk);
      end
    end
  endtask

  // Start stays high after acceptance so that the next item can follow at once.
  task automatic send(input op_t op, input int a, b, input logic [OFS_W-1:0] dx, dy);
    start      <= 1'b1;
    command    <= op;
    from_group <= a[GROUP_W-1:0];
    to_group   <= b[GROUP_W-1:0];
    offset_x   <= dx;
    offset_y   <= dy;
    do @(posedge clk); while (busy);
    op_counts[op]++;
    pace();
  endtask

  task automatic drain();
    start <= 1'b0;
    do @(posedge clk); while (outstanding != 0);
  endtask

  task automatic set_size(input int v);
    drain();
    cfg_valid <= 1'b1;
    cfg_data  <= v[CFG_W-1:0];
    do @(posedge clk); while (!cfg_ready);
    cfg_valid <= 1'b0;
    size_writes++;
    live = (v > MAX_GROUPS) ? MAX_GROUPS : v;
  endtask

  function automatic int inner_group();
    if (live < 2) return $urandom_range(0, GROUP_TOP);
    return $urandom_range(1, live - 1);
  endfunction

  task automatic random_item(input int close_pct);
    int               pick;
    int               a;
    int               b;
    int               read_top;
    logic [OFS_W-1:0] dx;
    logic [OFS_W-1:0] dy;
    pick = $urandom_range(0, 99);
    a = inner_group();
    b = inner_group();
    dx = anchor_x[b] - anchor_x[a];
    dy = anchor_y[b] - anchor_y[a];
    read_top = (live > GROUP_TOP) ? GROUP_TOP : live;
    if (pick < 3) begin
      send(OP_CLEAR, $urandom_range(0, GROUP_TOP), $urandom_range(0, GROUP_TOP),
           $urandom(), $urandom());
      place_groups();
    end else if (pick < 3 + close_pct) begin
      send(OP_CLOSE, $urandom_range(0, GROUP_TOP), $urandom_range(0, GROUP_TOP),
           $urandom(), $urandom());
    end else if (pick < 50) begin
      // A few links with arbitrary offsets give mismatches and closure conflicts.
      if ($urandom_range(0, 9) == 0) begin
        dx = $urandom();
        dy = $urandom();
      end
      send(OP_ADD, a, b, dx, dy);
    end else if (pick < 56) begin
      send(OP_ADD, $urandom_range(0, GROUP_TOP), $urandom_range(0, GROUP_TOP),
           $urandom(), $urandom());
    end else if (pick < 92) begin
      if ($urandom_range(0, 3) == 0)
        send(OP_READ, $urandom_range(0, GROUP_TOP), $urandom_range(0, GROUP_TOP),
             $urandom(), $urandom());
      else
        send(OP_READ, $urandom_range(0, read_top), $urandom_range(0, read_top),
             $urandom(), $urandom());
    end else begin
      send(op_t'($urandom_range(0, 3)), $urandom_range(0, GROUP_TOP),
           $urandom_range(0, GROUP_TOP), $urandom(), $urandom());
    end
    // Now and then hold off until the block has answered everything.
    if ($urandom_range(0, 49) == 0) drain();
  endtask

  initial begin
    place_groups();
    repeat (10) @(posedge clk);
    rst <= 1'b0;

    // The size after reset is one, so no group is usable yet.
    send(OP_ADD, 1, 2, 32'h1, 32'h1);
    send(OP_CLOSE, 0, 0, '0, '0);

    set_size(5);
    send(OP_ADD, 3, 3, 32'h5, 32'h6);
    send(OP_ADD, 0, 0, 32'h5, 32'h6);
    send(OP_ADD, 0, 2, 32'h5, 32'h6);
    send(OP_ADD, 2, 5, 32'h5, 32'h6);
    send(OP_ADD, 63, 1, 32'h5, 32'h6);
    send(OP_ADD, 1, 2, 32'h7FFF_FFFF, 32'h8000_0000);
    send(OP_ADD, 2, 3, 32'h7FFF_FFFF, 32'hFFFF_FFFF);
    send(OP_ADD, 1, 2, 32'h7FFF_FFFF, 32'h8000_0000);
    send(OP_ADD, 1, 2, 32'h0, 32'h0);
    send(OP_ADD, 3, 4, 32'h8000_0000, 32'h0000_0001);
    send(OP_CLOSE, 0, 0, '0, '0);
    send(OP_READ, 1, 3, '0, '0);
    send(OP_READ, 1, 4, '0, '0);
    send(OP_READ, 1, 2, '0, '0);
    send(OP_READ, 63, 63, '0, '0);
    // A reverse link that does not cancel its partner makes the next close inconsistent.
    send(OP_ADD, 2, 1, 32'h7FFF_FFFF, 32'h8000_0000);
    send(OP_CLOSE, 0, 0, '0, '0);

    // With no groups in use, adds are invalid and a close finds nothing.
    set_size(0);
    send(OP_ADD, 1, 2, 32'h1, 32'h1);
    send(OP_CLOSE, 0, 0, '0, '0);
    send(OP_READ, 1, 3, '0, '0);

    set_size(127);
    send(OP_ADD, 63, 1, 32'hFFFF_FFFF, 32'h0);
    send(OP_CLOSE, 0, 0, '0, '0);
    send(OP_CLEAR, 0, 0, '0, '0);
    send(OP_READ, 1, 2, '0, '0);

    foreach (phase_sizes[i]) begin
      set_size(phase_sizes[i]);
      repeat (PHASE_ITEMS) random_item(8);
    end
    // Full-size tables are slow to close, so these phases are short and close rarely.
    set_size(64);
    repeat (WIDE_ITEMS) random_item(3);
    set_size(127);
    repeat (WIDE_ITEMS) random_item(3);
    set_size(65);
    repeat (WIDE_ITEMS) random_item(3);

    drain();
    repeat (100) @(posedge clk);
    $display("Covered %0d clears, %0d adds, %0d closes and %0d reads over %0d size writes.",
             op_counts[OP_CLEAR], op_counts[OP_ADD], op_counts[OP_CLOSE], op_counts[OP_READ],
             size_writes);
    $display("Compared %0d results with %0d mismatches.", results_seen, failures);
    if (failures == 0 && outstanding == 0)
      $display("Simulation PASSED");
    else
      $display("Simulation FAILED");
    $finish;
  end

  initial begin
    repeat (LIMIT_CYCLES) @(posedge clk);
    $display("Timed out after %0d cycles with %0d results outstanding.",
             LIMIT_CYCLES, outstanding);
    $display("Simulation FAILED");
    $finish;
  end

endmodule
